@@ hw/rtl/tscl_pkg.sv @@
// Shared types, constants and helpers for the tire slip constraint linearizer.
package tscl_pkg;

  localparam int FRAC_BITS = 16;
  localparam int QBITS     = 31;                 // quotient bits below the saturation point
  localparam int DIV_NW    = 62 + FRAC_BITS;     // widest dividend: L*|vx| << FRAC_BITS
  localparam int DIV_LAT   = QBITS + 1;
  localparam int COR_STEPS = 30;
  localparam int COR_LAT   = COR_STEPS + 3;      // lzc, shift, iterations, round
  localparam int NORM_TOP  = 59;

  localparam logic [16:0] STEER_ONE = 17'(64'd1 << FRAC_BITS);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_REAR  = 2'd0;
  localparam reg_idx_t REG_FRONT = 2'd1;
  localparam reg_idx_t REG_AMAX  = 2'd2;

  localparam logic [29:0] ATAN_Q30 [COR_STEPS] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1
  };

  // state that rides alongside the divider and cordic pipes
  typedef struct packed {
    logic               front;
    logic               zero;
    logic               a_neg;
    logic               vx_neg;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // apply sign to a magnitude quotient and saturate
  function automatic logic signed [31:0] quot_signed(input logic [QBITS-1:0] q,
                                                     input logic ovf, input logic neg);
    logic signed [31:0] r;
    logic signed [31:0] m;
    m = $signed({1'b0, q});
    if (ovf) r = neg ? 32'sh80000000 : 32'sh7FFFFFFF;
    else r = neg ? -m : m;
    return r;
  endfunction

endpackage

@@ hw/rtl/tscl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^QBITS.
module tscl_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tscl_pkg::DIV_NW-1:0] num,
  input  logic [63:0]                den,
  output logic [tscl_pkg::QBITS-1:0] quot,
  output logic                       ovf
);
  import tscl_pkg::*;

  logic [63:0]       rem_r [0:QBITS];
  logic [63:0]       dsr_r [0:QBITS];
  logic [QBITS-1:0]  low_r [0:QBITS];
  logic [QBITS-1:0]  q_r   [0:QBITS];
  logic              ovf_r [0:QBITS];

  logic [63:0]       rem_nxt [1:QBITS];
  logic [QBITS-1:0]  q_nxt   [1:QBITS];
  logic [64:0]       trial   [1:QBITS];
  logic [63:0]       hi;

  assign hi = 64'(num[DIV_NW-1:QBITS]);

  always_comb begin
    for (int k = 1; k <= QBITS; k++) begin
      trial[k] = {rem_r[k-1], low_r[k-1][QBITS-1]};
      if (trial[k] >= {1'b0, dsr_r[k-1]}) begin
        rem_nxt[k] = 64'(trial[k] - {1'b0, dsr_r[k-1]});
        q_nxt[k]   = {q_r[k-1][QBITS-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][63:0];
        q_nxt[k]   = {q_r[k-1][QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi;
      dsr_r[0] <= den;
      low_r[0] <= num[QBITS-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (hi >= den);
      for (int k = 1; k <= QBITS; k++) begin
        rem_r[k] <= rem_nxt[k];
        dsr_r[k] <= dsr_r[k-1];
        low_r[k] <= low_r[k-1] << 1;
        q_r[k]   <= q_nxt[k];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quot = q_r[QBITS];
  assign ovf  = ovf_r[QBITS];

endmodule

@@ hw/rtl/tscl_cordic.sv @@
// Pipelined CORDIC vectoring arctangent of num/dnm, result rounded to Q format.
module tscl_cordic (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] dnm,
  output logic [31:0] ang
);
  import tscl_pkg::*;

  logic [31:0]        n0_r, d0_r;
  logic [5:0]         sh0_r;
  logic               nz0_r;
  logic signed [63:0] x_r [0:COR_STEPS];
  logic signed [63:0] y_r [0:COR_STEPS];
  logic signed [32:0] z_r [0:COR_STEPS];
  logic               nz_r [0:COR_STEPS];
  logic [31:0]        ang_r;

  logic signed [63:0] x_nxt [1:COR_STEPS];
  logic signed [63:0] y_nxt [1:COR_STEPS];
  logic signed [32:0] z_nxt [1:COR_STEPS];
  logic [31:0]        or_w;
  logic [4:0]         msb;
  logic signed [32:0] zc;
  logic [32:0]        rnd;

  assign or_w = num | dnm;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (or_w[i]) msb = 5'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < COR_STEPS; i++) begin
      if (!y_r[i][63]) begin
        x_nxt[i+1] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] + $signed({3'b0, ATAN_Q30[i]});
      end else begin
        x_nxt[i+1] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i+1] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i+1] = z_r[i] - $signed({3'b0, ATAN_Q30[i]});
      end
    end
  end

  // negative residue clamps to zero, then round half up
  assign zc  = z_r[COR_STEPS][32] ? 33'sd0 : z_r[COR_STEPS];
  assign rnd = (33'(zc) + (33'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en) begin
      n0_r  <= num;
      d0_r  <= dnm;
      sh0_r <= 6'(NORM_TOP - int'(msb));
      nz0_r <= (num == '0);
      x_r[0]  <= $signed(64'(d0_r) << sh0_r);
      y_r[0]  <= $signed(64'(n0_r) << sh0_r);
      z_r[0]  <= '0;
      nz_r[0] <= nz0_r;
      for (int i = 1; i <= COR_STEPS; i++) begin
        x_r[i]  <= x_nxt[i];
        y_r[i]  <= y_nxt[i];
        z_r[i]  <= z_nxt[i];
        nz_r[i] <= nz_r[i-1];
      end
      ang_r <= nz_r[COR_STEPS] ? 32'd0 : rnd[31:0];
    end
  end

  assign ang = ang_r;

endmodule

@@ hw/rtl/tire_slip_constraint_linearizer_core.sv @@
// Top level of the tire slip constraint linearizer pipeline.
//
// Input channel in_*: one beat per constraint (axle select plus vehicle state),
// taken when in_valid is high and in_stall is low. Output channel out_*: one
// beat per input beat, same order, taken when out_valid is high and out_stall
// is low. Config channel cfg_*: cfg_ready is always high; index 0 rear axle
// distance, 1 front axle distance, 2 max slip angle; other indexes are
// dropped. Write config only while the pipe is empty.
// Throughput is one beat per cycle while the output is not stalled. A beat
// passes 5 front stages (input, multiply, lever sum, squares, denominator),
// 32 divider stages, a gradient multiply stage and the bound sum stage; the
// 33-stage arctangent runs beside the divider and gradient multiply stages.
// A stall while out_valid is high freezes the whole pipe, the output register
// holding its beat, and raises in_stall in the same cycle; nothing is dropped.
// Synchronous reset clears all valid bits and the config registers to zero.
module tire_slip_constraint_linearizer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_long_speed,
  input  logic signed [31:0] in_lat_speed,
  input  logic signed [31:0] in_yaw_rate,
  input  logic signed [31:0] in_steer_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_grad_long_speed,
  output logic signed [31:0] out_grad_lat_speed,
  output logic signed [31:0] out_grad_yaw_rate,
  output logic [16:0]        out_grad_steer,
  output logic signed [31:0] out_lower_limit,
  output logic signed [31:0] out_upper_limit,
  output logic               out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  tscl_pkg::reg_idx_t cfg_index,
  input  logic [31:0]        cfg_data
);
  import tscl_pkg::*;

  logic en;
  logic [30:0] lr_r, lf_r, amax_r;

  // stage 1
  logic s1_vld_r, s1_front_r;
  logic signed [31:0] s1_vx_r, s1_vy_r, s1_wz_r;
  logic [30:0] s1_l_r;
  // stage 2
  logic s2_vld_r, s2_front_r;
  logic signed [31:0] s2_vx_r, s2_vy_r, s2_wz_r;
  logic [30:0] s2_l_r;
  logic signed [63:0] s2_prod_r;
  // stage 3
  logic s3_vld_r, s3_front_r;
  logic signed [31:0] s3_vx_r, s3_vy_r, s3_wz_r, s3_a_r;
  logic [30:0] s3_l_r;
  // stage 4
  logic s4_vld_r;
  side_t s4_sd_r;
  logic [63:0] s4_a2_r, s4_v2_r;
  logic [62:0] s4_lv_r;
  logic [31:0] s4_ua_r, s4_uvx_r;
  // stage 5
  logic s5_vld_r;
  side_t s5_sd_r;
  logic [63:0] s5_den_r;
  logic [DIV_NW-1:0] s5_na_r, s5_nv_r, s5_nl_r;
  logic [31:0] s5_ua_r, s5_uvx_r;
  // delay alongside the divider
  logic  vd_r [0:DIV_LAT-1];
  side_t sd_r [0:DIV_LAT-1];
  // stage 6
  logic s6_vld_r;
  side_t s6_sd_r;
  logic signed [31:0] s6_gvx_r, s6_gvy_r, s6_gwz_r;
  logic signed [63:0] s6_p1_r, s6_p2_r, s6_p3_r;

  logic out_valid_r, out_status_r;
  logic signed [31:0] out_gvx_r, out_gvy_r, out_gwz_r, out_lo_r, out_hi_r;
  logic [16:0] out_gs_r;

  logic signed [63:0] lw, a_wide, a2, v2, pr1, pr2, pr3, t_s, jsum;
  logic signed [63:0] amax_s;
  logic [62:0] lv;
  logic [31:0] ua, uvx;
  logic [QBITS-1:0] q_a, q_v, q_l;
  logic ovf_a, ovf_v, ovf_l;
  logic [31:0] ang;
  logic signed [31:0] gvx, gvy, gwz;
  side_t sd_d;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= '0;
      lf_r   <= '0;
      amax_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REAR:  lr_r   <= cfg_data[30:0];
        REG_FRONT: lf_r   <= cfg_data[30:0];
        REG_AMAX:  amax_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // lever term and lateral slip numerator
  assign lw     = s2_prod_r >>> FRAC_BITS;
  assign a_wide = s2_front_r ? 64'(s2_vy_r) + lw : 64'(s2_vy_r) - lw;

  assign ua  = s3_a_r[31] ? 32'(-s3_a_r) : 32'(s3_a_r);
  assign uvx = s3_vx_r[31] ? 32'(-s3_vx_r) : 32'(s3_vx_r);
  assign a2  = s3_a_r * s3_a_r;
  assign v2  = s3_vx_r * s3_vx_r;
  assign lv  = s3_l_r * uvx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_front_r <= in_cmd;
      s1_vx_r    <= in_long_speed;
      s1_vy_r    <= in_lat_speed;
      s1_wz_r    <= in_yaw_rate;
      s1_l_r     <= in_cmd ? lf_r : lr_r;

      s2_front_r <= s1_front_r;
      s2_vx_r    <= s1_vx_r;
      s2_vy_r    <= s1_vy_r;
      s2_wz_r    <= s1_wz_r;
      s2_l_r     <= s1_l_r;
      s2_prod_r  <= $signed({1'b0, s1_l_r}) * s1_wz_r;

      s3_front_r <= s2_front_r;
      s3_vx_r    <= s2_vx_r;
      s3_vy_r    <= s2_vy_r;
      s3_wz_r    <= s2_wz_r;
      s3_l_r     <= s2_l_r;
      s3_a_r     <= sat32(a_wide);

      s4_sd_r.front  <= s3_front_r;
      s4_sd_r.zero   <= (s3_vx_r == '0);
      s4_sd_r.a_neg  <= s3_a_r[31];
      s4_sd_r.vx_neg <= s3_vx_r[31];
      s4_sd_r.vx     <= s3_vx_r;
      s4_sd_r.vy     <= s3_vy_r;
      s4_sd_r.wz     <= s3_wz_r;
      s4_a2_r        <= a2;
      s4_v2_r        <= v2;
      s4_lv_r        <= lv;
      s4_ua_r        <= ua;
      s4_uvx_r       <= uvx;

      s5_sd_r  <= s4_sd_r;
      s5_den_r <= s4_a2_r + s4_v2_r;
      s5_na_r  <= DIV_NW'(s4_ua_r) << (2 * FRAC_BITS);
      s5_nv_r  <= DIV_NW'(s4_uvx_r) << (2 * FRAC_BITS);
      s5_nl_r  <= DIV_NW'(s4_lv_r) << FRAC_BITS;
      s5_ua_r  <= s4_ua_r;
      s5_uvx_r <= s4_uvx_r;
    end
  end

  tscl_div u_div_a (.clk(clk), .en(en), .num(s5_na_r), .den(s5_den_r),
                    .quot(q_a), .ovf(ovf_a));
  tscl_div u_div_v (.clk(clk), .en(en), .num(s5_nv_r), .den(s5_den_r),
                    .quot(q_v), .ovf(ovf_v));
  tscl_div u_div_l (.clk(clk), .en(en), .num(s5_nl_r), .den(s5_den_r),
                    .quot(q_l), .ovf(ovf_l));
  tscl_cordic u_cordic (.clk(clk), .en(en), .num(s5_ua_r), .dnm(s5_uvx_r), .ang(ang));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= s5_vld_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= s5_sd_r;
      for (int k = 1; k < DIV_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  assign sd_d = sd_r[DIV_LAT-1];
  assign gvx  = quot_signed(q_a, ovf_a, sd_d.a_neg);
  assign gvy  = quot_signed(q_v, ovf_v, !sd_d.vx_neg);
  assign gwz  = quot_signed(q_l, ovf_l, sd_d.front ? !sd_d.vx_neg : sd_d.vx_neg);
  assign pr1  = gvx * sd_d.vx;
  assign pr2  = gvy * sd_d.vy;
  assign pr3  = gwz * sd_d.wz;

  // steering term cancels between J.x and alpha
  assign t_s    = (s6_sd_r.a_neg != s6_sd_r.vx_neg) ? -$signed({32'b0, ang})
                                                    : $signed({32'b0, ang});
  assign jsum   = s6_p1_r + s6_p2_r + s6_p3_r + t_s;
  assign amax_s = $signed({33'b0, amax_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s6_vld_r    <= vd_r[DIV_LAT-1];
      out_valid_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sd_r  <= sd_d;
      s6_gvx_r <= gvx;
      s6_gvy_r <= gvy;
      s6_gwz_r <= gwz;
      s6_p1_r  <= pr1 >>> FRAC_BITS;
      s6_p2_r  <= pr2 >>> FRAC_BITS;
      s6_p3_r  <= pr3 >>> FRAC_BITS;

      out_gs_r     <= s6_sd_r.front ? STEER_ONE : 17'd0;
      out_status_r <= s6_sd_r.zero;
      if (s6_sd_r.zero) begin
        out_gvx_r <= '0;
        out_gvy_r <= '0;
        out_gwz_r <= '0;
        out_lo_r  <= '0;
        out_hi_r  <= '0;
      end else begin
        out_gvx_r <= s6_gvx_r;
        out_gvy_r <= s6_gvy_r;
        out_gwz_r <= s6_gwz_r;
        out_lo_r  <= sat32(jsum - amax_s);
        out_hi_r  <= sat32(jsum + amax_s);
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_grad_long_speed = out_gvx_r;
  assign out_grad_lat_speed  = out_gvy_r;
  assign out_grad_yaw_rate   = out_gwz_r;
  assign out_grad_steer      = out_gs_r;
  assign out_lower_limit     = out_lo_r;
  assign out_upper_limit     = out_hi_r;
  assign out_status          = out_status_r;

endmodule

@@ tb/tb_tire_slip_constraint_linearizer_core.sv @@
// Self-checking testbench for the tire slip constraint linearizer core.
module tb_tire_slip_constraint_linearizer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tscl_pkg::*;

  localparam reg_idx_t REG_UNUSED = 2'd3;
  localparam int       IDLE_LIMIT = 3000;
  localparam int       DRAIN_CYC  = 45;
  localparam longint   Q1         = 64'sd65536;

  typedef struct {
    logic signed [31:0] gvx;
    logic signed [31:0] gvy;
    logic signed [31:0] gwz;
    logic [16:0]        gst;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               status;
  } slip_res_t;

  typedef struct {
    logic               cmd;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
    logic signed [31:0] st;
    bit                 typed;
    slip_res_t          want;
  } beat_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_cmd = 1'b0;
  logic signed [31:0] in_long_speed = '0;
  logic signed [31:0] in_lat_speed = '0;
  logic signed [31:0] in_yaw_rate = '0;
  logic signed [31:0] in_steer_angle = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_grad_long_speed;
  logic signed [31:0] out_grad_lat_speed;
  logic signed [31:0] out_grad_yaw_rate;
  logic [16:0]        out_grad_steer;
  logic signed [31:0] out_lower_limit;
  logic signed [31:0] out_upper_limit;
  logic               out_status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  reg_idx_t           cfg_index = REG_REAR;
  logic [31:0]        cfg_data = '0;

  tire_slip_constraint_linearizer_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longint    rear_dist, front_dist, slip_max;
  slip_res_t pending_slip[$];
  int        errors, beats_in, beats_out, zero_speed_seen, front_seen, cfg_writes;
  bit        quiet;

  localparam slip_res_t ZERO_REAR  = '{0, 0, 0, 17'd0, 0, 0, 1'b1};
  localparam slip_res_t ZERO_FRONT = '{0, 0, 0, 17'd65536, 0, 0, 1'b1};

  // directed beats; typed expectations hold only with all registers at reset
  beat_row_t dir_rows [18] = '{
    '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1, ZERO_REAR},
    '{1'b1, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, ZERO_FRONT},
    '{1'b0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1,
      '{0, -32'sd65536, 0, 17'd0, 0, 0, 1'b0}},
    '{1'b1, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1,
      '{0, -32'sd65536, 0, 17'd65536, 0, 0, 1'b0}},
    '{1'b0, -32'sd65536, 32'sd0, 32'sd0, 32'sd0, 1'b1,
      '{0, 32'sd65536, 0, 17'd0, 0, 0, 1'b0}},
    '{1'b0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, ZERO_REAR},
    '{1'b1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, ZERO_REAR},
    '{1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, ZERO_REAR},
    '{1'b1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, ZERO_REAR},
    '{1'b0, 32'sd1, 32'sh80000000, 32'sd1, 32'sd0, 1'b0, ZERO_REAR},
    '{1'b1, 32'sh80000000, 32'sd1, 32'sh7FFFFFFF, 32'sd1, 1'b0, ZERO_REAR},
    '{1'b0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 1'b0, ZERO_REAR},
    '{1'b1, -32'sd1, 32'sd1, -32'sd1, -32'sd1, 1'b0, ZERO_REAR},
    '{1'b0, 32'sd655360, 32'sd32768, 32'sd19661, 32'sd3277, 1'b0, ZERO_REAR},
    '{1'b1, 32'sd655360, 32'sd32768, 32'sd19661, 32'sd3277, 1'b0, ZERO_REAR},
    '{1'b1, -32'sd196608, 32'sd131072, -32'sd65536, -32'sd6554, 1'b0, ZERO_REAR},
    '{1'b0, 32'sh7FFFFFFF, 32'sd0, 32'sd0, 32'sd0, 1'b0, ZERO_REAR},
    '{1'b1, 32'sd65536, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, ZERO_REAR}
  };

  function automatic longint clamp_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // floor(n * 2^s / d), capped at 2^32
  function automatic longint unsigned scaled_quotient(longint unsigned n, int s,
                                                      longint unsigned d);
    longint unsigned q, r, cap;
    cap = 64'd1 << 32;
    q = n / d;
    r = n % d;
    if (q > cap) return cap;
    for (int i = 0; i < s; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r = r - d;
        q = q + 1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic longint signed_grad(longint unsigned m, bit neg);
    return clamp_s32(neg ? -longint'(m) : longint'(m));
  endfunction

  // atan(num/dnm) by vectoring CORDIC, Q30 angle rounded to Q16
  function automatic longint slip_atan(longint unsigned num, longint unsigned dnm);
    longint x, y, z, nx;
    z = 0;
    if (num == 0) return 0;
    while ((num > dnm ? num : dnm) < (64'd1 << 59)) begin
      num = num << 1;
      dnm = dnm << 1;
    end
    x = dnm;
    y = num;
    for (int i = 0; i < COR_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ATAN_Q30[i]);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ATAN_Q30[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    return (z + (64'sd1 << 13)) >>> 14;
  endfunction

  function automatic slip_res_t linearize_slip(logic cmd, logic signed [31:0] vx_i,
                                               logic signed [31:0] vy_i,
                                               logic signed [31:0] wz_i,
                                               logic signed [31:0] st_i);
    slip_res_t r;
    longint vx, vy, wz, st, lev, a, gsteer, gvx, gvy, gwz, t, alpha, jx;
    longint unsigned den, uvx;
    vx = vx_i; vy = vy_i; wz = wz_i; st = st_i;
    lev = cmd ? front_dist : rear_dist;
    gsteer = cmd ? Q1 : 0;
    r.gst = gsteer[16:0];
    if (vx == 0) begin
      r.gvx = 0; r.gvy = 0; r.gwz = 0; r.lo = 0; r.hi = 0; r.status = 1'b1;
      return r;
    end
    a = clamp_s32(cmd ? vy + ((lev * wz) >>> 16) : vy - ((lev * wz) >>> 16));
    uvx = abs64(vx);
    den = longint'(a * a) + longint'(vx * vx);
    gvx = signed_grad(scaled_quotient(abs64(a), 32, den), a < 0);
    gvy = signed_grad(scaled_quotient(uvx, 32, den), vx > 0);
    gwz = signed_grad(scaled_quotient(longint'(lev) * uvx, 16, den),
                      cmd ? (vx > 0) : (vx < 0));
    t = slip_atan(abs64(a), uvx);
    if ((a < 0) != (vx < 0)) t = -t;
    alpha = -t + (cmd ? st : 0);
    jx = ((gvx * vx) >>> 16) + ((gvy * vy) >>> 16) + ((gwz * wz) >>> 16)
       + ((gsteer * st) >>> 16);
    r.gvx = gvx[31:0];
    r.gvy = gvy[31:0];
    r.gwz = gwz[31:0];
    r.lo = clamp_s32(-slip_max + jx - alpha);
    r.hi = clamp_s32(slip_max + jx - alpha);
    r.status = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch beat %0d %s: got %0d want %0d", beats_out, what, got, want);
    errors++;
  endtask

  // result side: compare each accepted beat with the oldest expectation
  always @(posedge clk) begin
    slip_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_slip.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_slip.pop_front();
        if (out_grad_long_speed !== w.gvx) report_mismatch("grad_long_speed", out_grad_long_speed, w.gvx);
        if (out_grad_lat_speed !== w.gvy) report_mismatch("grad_lat_speed", out_grad_lat_speed, w.gvy);
        if (out_grad_yaw_rate !== w.gwz) report_mismatch("grad_yaw_rate", out_grad_yaw_rate, w.gwz);
        if (out_grad_steer !== w.gst) report_mismatch("grad_steer", out_grad_steer, w.gst);
        if (out_lower_limit !== w.lo) report_mismatch("lower_limit", out_lower_limit, w.lo);
        if (out_upper_limit !== w.hi) report_mismatch("upper_limit", out_upper_limit, w.hi);
        if (out_status !== w.status) report_mismatch("status", out_status, w.status);
      end
      beats_out++;
    end
  end

  always @(negedge clk)
    out_stall <= !quiet && ($urandom_range(99) < 11);

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    int idle_cyc;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cyc = 0;
    else
      idle_cyc++;
    if (idle_cyc >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  task automatic cfg_write(reg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_REAR:  rear_dist = data[30:0];
      REG_FRONT: front_dist = data[30:0];
      REG_AMAX:  slip_max = data[30:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_axles(logic [31:0] lr, logic [31:0] lf, logic [31:0] amax);
    cfg_write(REG_REAR, lr);
    cfg_write(REG_FRONT, lf);
    cfg_write(REG_AMAX, amax);
  endtask

  task automatic send_beat(logic cmd, logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] wz, logic signed [31:0] st,
                           bit typed, slip_res_t want);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_long_speed <= vx;
    in_lat_speed <= vy;
    in_yaw_rate <= wz;
    in_steer_angle <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_slip.push_back(typed ? want : linearize_slip(cmd, vx, vy, wz, st));
    beats_in++;
    if (vx == 0) zero_speed_seen++;
    if (cmd) front_seen++;
    @(negedge clk);
  endtask

  // pipe empty, then let the deepest stage flush before touching registers
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_slip.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic logic [31:0] vehicle_field();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return 32'd0;
      3:       return 32'h7FFFFFFF;
      4:       return 32'h80000000;
      default: return 32'($urandom_range(32'h3FFFFF)) - 32'h200000;
    endcase
  endfunction

  task automatic send_dir_rows(bit use_typed);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].cmd, dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].wz,
                dir_rows[i].st, use_typed && dir_rows[i].typed, dir_rows[i].want);
  endtask

  task automatic send_random(int count);
    slip_res_t none;
    none = ZERO_REAR;
    repeat (count) begin
      quiet = (beats_in >= 300 && beats_in < 400);
      send_beat(1'($urandom_range(1)), vehicle_field(), vehicle_field(), vehicle_field(),
                vehicle_field(), 1'b0, none);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rear_dist = 0;
    front_dist = 0;
    slip_max = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_dir_rows(1'b1);
    drain_pipe();
    set_axles(32'd98304, 32'd78643, 32'd6554);
    send_random(200);
    drain_pipe();
    // register extremes; bit 31 must be dropped on the front distance
    set_axles(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h7FFFFFFF);
    send_dir_rows(1'b0);
    send_random(80);
    drain_pipe();
    cfg_write(REG_UNUSED, 32'h12345678);
    set_axles(32'd0, 32'd131072, 32'd0);
    send_random(100);
    repeat (2) begin
      drain_pipe();
      set_axles($urandom_range(32'h40000), $urandom, $urandom_range(32'h20000));
      send_random(85);
    end
    drain_pipe();

    if (pending_slip.size() != 0)
      report_mismatch("missing results", 0, pending_slip.size());
    $display("covered %0d beats in, %0d out, %0d front, %0d zero speed, %0d register writes",
             beats_in, beats_out, front_seen, zero_speed_seen, cfg_writes);
    $display("mismatches: %0d", errors);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
